// ----- design/meb_pkg.sv -----
package meb_pkg;

  localparam int FRAC_BITS_DEFAULT = 28;

  localparam int COORD_W     = 32;
  localparam int IDX_W       = 12;
  localparam int ITER_W      = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int S_DATA_W = 2 * IDX_W;
  localparam int M_DATA_W = 2 * IDX_W + ITER_W;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITERS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_X_LEFT    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_Y_LOWER   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_X_STEP    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_Y_STEP    = 3'd4;

  localparam logic [ITER_W-1:0]         MAX_ITERS_RESET = 24'd10000;
  localparam logic signed [COORD_W-1:0] X_LEFT_RESET    = -32'sd536870912;
  localparam logic signed [COORD_W-1:0] Y_LOWER_RESET   = -32'sd536870912;
  localparam logic signed [COORD_W-1:0] X_STEP_RESET    = 32'sd262144;
  localparam logic signed [COORD_W-1:0] Y_STEP_RESET    = 32'sd262144;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  // one mapped pixel on its way to the iteration engine
  typedef struct packed {
    logic [IDX_W-1:0]          col;
    logic [IDX_W-1:0]          row;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } map_item_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [65:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[COORD_W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[COORD_W-1:0];
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

// ----- design/meb_front.sv -----
module meb_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [meb_pkg::S_DATA_W-1:0]        s_tdata,  // pixel_col, pixel_row
  input  logic signed [meb_pkg::COORD_W-1:0]  x_left,
  input  logic signed [meb_pkg::COORD_W-1:0]  y_lower,
  input  logic signed [meb_pkg::COORD_W-1:0]  x_step,
  input  logic signed [meb_pkg::COORD_W-1:0]  y_step,
  output meb_pkg::map_item_t                  item,
  output logic                                item_valid,
  input  logic                                item_ready
);

  localparam int PROD_W = meb_pkg::IDX_W + 1 + meb_pkg::COORD_W;

  logic                           v1;
  logic [meb_pkg::IDX_W-1:0]      col1;
  logic [meb_pkg::IDX_W-1:0]      row1;
  logic signed [PROD_W-1:0]       px;
  logic signed [PROD_W-1:0]       py;
  logic                           accept;

  assign s_tready   = !v1 || item_ready;
  assign accept     = s_tvalid && s_tready;
  assign item_valid = v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (item_ready) begin
      v1 <= 1'b0;
    end
  end

  // column/row scaled by the step, registered before the offset add
  always_ff @(posedge clk) begin
    if (accept) begin
      col1 <= s_tdata[meb_pkg::IDX_W-1:0];
      row1 <= s_tdata[2*meb_pkg::IDX_W-1:meb_pkg::IDX_W];
      px   <= $signed({1'b0, s_tdata[meb_pkg::IDX_W-1:0]}) * x_step;
      py   <= $signed({1'b0, s_tdata[2*meb_pkg::IDX_W-1:meb_pkg::IDX_W]}) * y_step;
    end
  end

  always_comb begin
    item.col = col1;
    item.row = row1;
    item.cx  = meb_pkg::sat32(66'(x_left) + 66'(px));
    item.cy  = meb_pkg::sat32(66'(y_lower) + 66'(py));
  end

endmodule

// ----- design/meb_queue.sv -----
module meb_queue (
  input  logic               clk,
  input  logic               rst,
  input  meb_pkg::map_item_t in_item,
  input  logic               in_valid,
  output logic               in_ready,
  output meb_pkg::map_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);

  localparam int DEPTH = meb_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  meb_pkg::map_item_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               push;
  logic               pop;

  assign in_ready  = fill != CNT_W'(DEPTH);
  assign out_valid = fill != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

// ----- design/meb_iter.sv -----
module meb_iter #(
  parameter int FRAC_BITS = meb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [meb_pkg::ITER_W-1:0]   max_iters,
  input  meb_pkg::map_item_t           item,
  input  logic                         item_valid,
  output logic                         item_ready,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [meb_pkg::M_DATA_W-1:0] m_tdata  // out_col, out_row, iteration_count
);

  localparam bit          CAN_ESCAPE = (2 * FRAC_BITS + 2) < 64;
  localparam logic [63:0] THRESH     = CAN_ESCAPE ? (64'd1 << (2 * FRAC_BITS + 2)) : 64'd0;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQ   = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t                           state;
  logic [meb_pkg::IDX_W-1:0]        col;
  logic [meb_pkg::IDX_W-1:0]        row;
  logic signed [meb_pkg::COORD_W-1:0] cx;
  logic signed [meb_pkg::COORD_W-1:0] cy;
  logic signed [meb_pkg::COORD_W-1:0] x;
  logic signed [meb_pkg::COORD_W-1:0] y;
  logic signed [63:0]               xx;
  logic signed [63:0]               yy;
  logic signed [63:0]               xy;
  logic [meb_pkg::ITER_W-1:0]       count;
  logic [meb_pkg::ITER_W-1:0]       limit;

  logic signed [63:0]               diff;
  logic signed [63:0]               re_sh;
  logic signed [63:0]               im_sh;
  logic signed [meb_pkg::COORD_W-1:0] nx;
  logic signed [meb_pkg::COORD_W-1:0] ny;
  logic [63:0]                      len;
  logic                             escaped;
  logic                             out_free;

  assign item_ready = state == ST_IDLE;
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    diff  = xx - yy;
    re_sh = diff >>> FRAC_BITS;
    im_sh = xy >>> (FRAC_BITS - 1);
    nx    = meb_pkg::sat32(66'(re_sh) + 66'(cx));
    ny    = meb_pkg::sat32(66'(im_sh) + 66'(cy));
    // squares of the current z: the escape test of the previous update
    len     = $unsigned(xx) + $unsigned(yy);
    escaped = CAN_ESCAPE && (count != '0) && (len >= THRESH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (escaped || count == limit) begin
            state <= ST_OUT;
          end else begin
            state <= ST_SQ;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          col   <= item.col;
          row   <= item.row;
          cx    <= item.cx;
          cy    <= item.cy;
          x     <= '0;
          y     <= '0;
          count <= '0;
          limit <= (max_iters == '0) ? meb_pkg::ITER_W'(1) : max_iters;
        end
      end
      ST_SQ: begin
        xx <= x * x;
        yy <= y * y;
        xy <= x * y;
      end
      ST_UPD: begin
        if (!(escaped || count == limit)) begin
          x     <= nx;
          y     <= ny;
          count <= count + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata <= {count, row, col};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time evaluator.
// Input stream (s_*): one pixel per transfer, s_tdata = {pixel_row, pixel_col}.
// Output stream (m_*): one result per pixel, in input order,
//   m_tdata = {iteration_count, out_row, out_col}.
// Configuration: cfg_we writes cfg_data into the register at cfg_addr
//   (0 max_iters, 1 x_left, 2 y_lower, 3 x_step, 4 y_step); other indexes are
//   ignored. Write only while no pixel is in flight.
// The front stage registers the column and row scaled by the step, adds the
// offsets to map (col, row) to c and pushes it into a four-entry queue, so new
// pixels are taken while the engine iterates. Each engine iteration forms the
// square products, then does the update and escape check, on its shared
// multipliers. The engine takes a new pixel only after it has handed the result
// of the last one to the output register, so pixels are iterated one at a time.
// A finished result waits in the output register while m_tready is low; the
// engine then holds, the queue fills and s_tready drops.
// Synchronous reset rst empties the queue and output and restores register
// defaults.
module mandelbrot_escape_time #(
  parameter int FRAC_BITS = meb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [meb_pkg::S_DATA_W-1:0]   s_tdata,  // pixel_col, pixel_row
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [meb_pkg::M_DATA_W-1:0]   m_tdata,  // out_col, out_row, iteration_count
  input  logic                           cfg_we,
  input  logic [meb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [meb_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [meb_pkg::ITER_W-1:0]         max_iters;
  logic signed [meb_pkg::COORD_W-1:0] x_left;
  logic signed [meb_pkg::COORD_W-1:0] y_lower;
  logic signed [meb_pkg::COORD_W-1:0] x_step;
  logic signed [meb_pkg::COORD_W-1:0] y_step;

  meb_pkg::map_item_t front_item;
  logic               front_valid;
  logic               front_ready;
  meb_pkg::map_item_t back_item;
  logic               back_valid;
  logic               back_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iters <= meb_pkg::MAX_ITERS_RESET;
      x_left    <= meb_pkg::X_LEFT_RESET;
      y_lower   <= meb_pkg::Y_LOWER_RESET;
      x_step    <= meb_pkg::X_STEP_RESET;
      y_step    <= meb_pkg::Y_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        meb_pkg::REG_MAX_ITERS: max_iters <= cfg_data[meb_pkg::ITER_W-1:0];
        meb_pkg::REG_X_LEFT:    x_left    <= cfg_data;
        meb_pkg::REG_Y_LOWER:   y_lower   <= cfg_data;
        meb_pkg::REG_X_STEP:    x_step    <= cfg_data;
        meb_pkg::REG_Y_STEP:    y_step    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  meb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .x_left     (x_left),
    .y_lower    (y_lower),
    .x_step     (x_step),
    .y_step     (y_step),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  meb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_item   (front_item),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_item  (back_item),
    .out_valid (back_valid),
    .out_ready (back_ready)
  );

  meb_iter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk        (clk),
    .rst        (rst),
    .max_iters  (max_iters),
    .item       (back_item),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
